@@ rtl/tmtd_pkg.sv @@
// Shared constants, register codes and types of the trimmed-mean threshold detector.
package tmtd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MAX_WINDOW  = 16;
    localparam int MIN_WINDOW  = 3;
    localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int BIT_W       = $clog2(SUM_BITS);
    localparam int MODE_BITS   = 3;
    localparam int CFG_BITS    = SAMPLE_BITS;
    localparam int IDX_BITS    = 2;

    localparam logic [CNT_BITS-1:0] WIN_RESET = CNT_BITS'(10);

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_WINDOW = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_LIMIT  = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_MODE   = 2'd2;

    // compare modes
    localparam logic [MODE_BITS-1:0] CMP_EQ = 3'd0;
    localparam logic [MODE_BITS-1:0] CMP_NE = 3'd1;
    localparam logic [MODE_BITS-1:0] CMP_LE = 3'd2;
    localparam logic [MODE_BITS-1:0] CMP_LT = 3'd3;
    localparam logic [MODE_BITS-1:0] CMP_GE = 3'd4;
    localparam logic [MODE_BITS-1:0] CMP_GT = 3'd5;

    typedef struct packed {
        logic                done;
        logic [SUM_BITS-1:0] quotient;
    } t_div_res;

endpackage

@@ rtl/tmtd_div.sv @@
// Restoring serial divider: one quotient bit per cycle.
module tmtd_div
    import tmtd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SUM_BITS-1:0] i_dividend,
    input  logic [CNT_BITS-1:0] i_divisor,
    output t_div_res            o_res
);

    logic                r_busy;
    logic                r_done;
    logic [BIT_W-1:0]    r_step;
    logic [CNT_BITS-1:0] r_rem;
    logic [CNT_BITS-1:0] r_div;
    logic [SUM_BITS-1:0] r_quo;

    logic [CNT_BITS:0]   n_trial;
    logic [CNT_BITS:0]   n_diff;
    logic                n_ge;
    logic [CNT_BITS-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_quo[SUM_BITS-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_ge    = (n_trial >= {1'b0, r_div});
        // remainder stays below the divisor, so it fits the narrow register
        n_rem   = n_ge ? n_diff[CNT_BITS-1:0] : n_trial[CNT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == BIT_W'(SUM_BITS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + BIT_W'(1);
                if (r_step == BIT_W'(SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SUM_BITS-2:0], n_ge};
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_quo;

endmodule

@@ rtl/trimmed_mean_threshold_detector.sv @@
// Top level: bit-serial window accumulator, trimmed mean and threshold compare.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_sample
//  result  | out       | o_out_valid / i_out_ready | o_mean_level, o_condition_met,
//          |           |                           | o_detect_event
//  config  | in        | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// A sample passes through accept, a bit-serial pass through the sum, min and max shift
// registers (min and max rotate over the sample bits only), then a fold into the window.
// The sample that closes a window then runs the serial divider, latches the mean and
// loads the output; a result still waiting on the output port delays only that load.
// Reset is synchronous and clears the window, the detect flag and the registers to defaults.
// A new sample is taken while an earlier result waits at the output.
module trimmed_mean_threshold_detector
    import tmtd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_mean_level,
    output logic                   o_condition_met,
    output logic                   o_detect_event,
    input  logic                   i_cfg_wr_en,
    input  logic [IDX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_BITS-1:0]    i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_END  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    logic [2:0]             r_state;
    logic [BIT_W-1:0]       r_bit;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_carry;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic                   r_lt;
    logic                   r_gt;
    logic [CNT_BITS-1:0]    r_taken;
    logic [CNT_BITS-1:0]    r_win;
    logic [SAMPLE_BITS-1:0] r_lim;
    logic [MODE_BITS-1:0]   r_mode;
    logic                   r_det;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_mean;
    logic                   r_out_hit;
    logic                   r_out_evt;

    logic                   n_active;
    logic                   n_sbit;
    logic                   n_sum_bit;
    logic                   n_carry;
    logic [SAMPLE_BITS-1:0] n_min;
    logic [SAMPLE_BITS-1:0] n_max;
    logic [CNT_BITS-1:0]    n_taken;
    logic [CNT_BITS-1:0]    n_eff;
    logic                   n_close;
    logic [SUM_BITS-1:0]    n_rest;
    logic [CNT_BITS-1:0]    n_divisor;
    logic                   n_hit;
    logic                   n_load;
    logic                   n_start;
    t_div_res               div_res;

    always_comb begin
        n_active  = (r_bit < BIT_W'(SAMPLE_BITS));
        n_sbit    = n_active & r_smp[0];
        n_sum_bit = r_sum[0] ^ n_sbit ^ r_carry;
        n_carry   = (r_sum[0] & n_sbit) | (r_carry & (r_sum[0] ^ n_sbit));

        n_min   = r_lt ? r_smp : r_min;
        n_max   = r_gt ? r_smp : r_max;
        n_taken = r_taken + CNT_BITS'(1);
        if (r_win < CNT_BITS'(MIN_WINDOW)) begin
            n_eff = CNT_BITS'(MIN_WINDOW);
        end else if (r_win > CNT_BITS'(MAX_WINDOW)) begin
            n_eff = CNT_BITS'(MAX_WINDOW);
        end else begin
            n_eff = r_win;
        end
        n_close   = (n_taken >= n_eff);
        n_rest    = r_sum - SUM_BITS'(n_min) - SUM_BITS'(n_max);
        n_divisor = n_taken - CNT_BITS'(2);
        n_start   = (r_state == S_END) && n_close;
        n_load    = (r_state == S_PUT) && (!r_out_valid || i_out_ready);

        unique case (r_mode)
            CMP_EQ:  n_hit = (r_mean == r_lim);
            CMP_NE:  n_hit = (r_mean != r_lim);
            CMP_LE:  n_hit = (r_mean <= r_lim);
            CMP_LT:  n_hit = (r_mean <  r_lim);
            CMP_GE:  n_hit = (r_mean >= r_lim);
            CMP_GT:  n_hit = (r_mean >  r_lim);
            default: n_hit = 1'b0;
        endcase
    end

    tmtd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_start),
        .i_dividend (n_rest),
        .i_divisor  (n_divisor),
        .o_res      (div_res)
    );

    // control, window state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_sum       <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_taken     <= '0;
            r_win       <= WIN_RESET;
            r_lim       <= '1;
            r_mode      <= CMP_EQ;
            r_det       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_WINDOW: r_win  <= i_cfg_data[CNT_BITS-1:0];
                    REG_LIMIT:  r_lim  <= i_cfg_data[SAMPLE_BITS-1:0];
                    REG_MODE:   r_mode <= i_cfg_data[MODE_BITS-1:0];
                    default: ;
                endcase
            end

            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_ACC;
                        r_bit   <= '0;
                    end
                end
                S_ACC: begin
                    r_sum <= {n_sum_bit, r_sum[SUM_BITS-1:1]};
                    if (n_active) begin
                        r_min <= {r_min[0], r_min[SAMPLE_BITS-1:1]};
                        r_max <= {r_max[0], r_max[SAMPLE_BITS-1:1]};
                    end
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(SUM_BITS - 1)) begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (n_close) begin
                        r_sum   <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_taken <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_min   <= n_min;
                        r_max   <= n_max;
                        r_taken <= n_taken;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (n_load) begin
                        r_det   <= n_hit;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload: sample rotator, serial compare flags, carry, mean, result beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_smp   <= i_sample;
            r_carry <= 1'b0;
            r_lt    <= 1'b0;
            r_gt    <= 1'b0;
        end else if (r_state == S_ACC) begin
            r_carry <= n_carry;
            if (n_active) begin
                // LSB first: a higher differing bit overrides the lower ones
                if (r_smp[0] != r_min[0]) r_lt <= r_min[0];
                if (r_smp[0] != r_max[0]) r_gt <= r_smp[0];
                r_smp <= {r_smp[0], r_smp[SAMPLE_BITS-1:1]};
            end
        end
        if (div_res.done) begin
            r_mean <= div_res.quotient[SAMPLE_BITS-1:0];
        end
        if (n_load) begin
            r_out_mean <= r_mean;
            r_out_hit  <= n_hit;
            r_out_evt  <= n_hit & ~r_det;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_mean_level    = r_out_mean;
    assign o_condition_met = r_out_hit;
    assign o_detect_event  = r_out_evt;

endmodule

@@ rtl/tmtd_checker.sv @@
// Port-level checks for the trimmed-mean threshold detector, bound to the top level.
module tmtd_checker
    import tmtd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_mean_level,
    input logic                   o_condition_met,
    input logic                   o_detect_event
);

    // a result beat held under stall keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_mean_level) && $stable(o_condition_met)
         && $stable(o_detect_event)))
        else $error("result beat changed under stall");

    // an event is only raised with the condition itself
    a_evt_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_detect_event || o_condition_met))
        else $error("detect event without condition");

    // a sample occupies the serial datapath, so no beat follows directly
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a sample beat");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind trimmed_mean_threshold_detector tmtd_checker u_tmtd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_mean_level    (o_mean_level),
    .o_condition_met (o_condition_met),
    .o_detect_event  (o_detect_event)
);
